[src/rbd_pkg.sv]
// Shared types and constants for the RSSI burst detector.
// Used by rbd_front, rbd_fifo, rbd_back and rssi_burst_detector.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

	localparam logic [7:0]  INVALID_RSSI = 8'd127;
	localparam logic [15:0] LEN_SAT      = 16'hFFFF;
	localparam logic [9:0]  US_PER_MS    = 10'd1000;

	// Input item modes.
	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_NOISE_FLOOR   = 3'd0;
	localparam logic [2:0] REG_FLOOR_DEFAULT = 3'd1;
	localparam logic [2:0] REG_FLOOR_MIN     = 3'd2;
	localparam logic [2:0] REG_FLOOR_MAX     = 3'd3;
	localparam logic [2:0] REG_SIGNAL_MARGIN = 3'd4;
	localparam logic [2:0] REG_WINDOW_MS     = 3'd5;
	localparam logic [2:0] REG_MAX_BURSTS    = 3'd6;

	// Result kinds.
	localparam logic KIND_RECORD  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One queue entry: the results caused by one input item.
	typedef struct packed {
		logic        has_rec;
		logic        has_sum;
		logic [31:0] rec_start;
		logic [15:0] rec_len;
		logic [7:0]  rec_peak;
		logic [31:0] win_len;
		logic [31:0] on_time;
		logic [15:0] count;
		logic [15:0] dropped;
		logic [6:0]  floor_val;
		logic [7:0]  win_peak;
	} rbd_entry_t;

endpackage

`default_nettype wire

[src/rbd_front.sv]
// Front part of the burst detector: configuration registers, window state and
// per-item classification. Pushes one entry per item that causes results.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [6:0]         rssi,
	input  wire logic [31:0]        time_us,
	input  wire logic               full,
	output logic                    push,
	output rbd_pkg::rbd_entry_t     push_entry
);
	import rbd_pkg::*;

	logic [6:0]  noise_floor_q, floor_default_q, floor_min_q, floor_max_q, signal_margin_q;
	logic [22:0] win_ms_q;
	logic [15:0] rec_limit_q;
	logic [31:0] deadline_q;

	logic        window_open_q;
	logic [31:0] window_start_q, latest_time_q, burst_begin_q, on_sum_q;
	logic [6:0]  threshold_q, floor_latched_q;
	logic        burst_on_q;
	logic [7:0]  burst_strongest_q, overall_strongest_q;
	logic [15:0] recorded_q, overflowed_q;

	logic        accept, is_sample, is_finish, win_step, start_ok;
	logic [32:0] deadline_prod;
	logic [31:0] deadline_new;
	logic [6:0]  floor_sel, thr_sel;
	logic [7:0]  v8, bs_mid, ov_mid;
	logic        active, ib_mid, end_w, close, rec;
	logic [31:0] bb_mid, t_now, elapsed, blen, on_next;
	logic [15:0] recorded_next, overflowed_next;

	assign item_stall = full;
	assign accept     = item_valid && !full;
	assign is_sample  = (mode == MODE_SAMPLE);
	assign is_finish  = (mode == MODE_FINISH);
	assign win_step   = accept && window_open_q && (is_sample || is_finish);
	assign start_ok   = (rec_limit_q != 16'd0) && (win_ms_q != 23'd0);

	// The deadline is formed once per window length write; the product fits in 33 bits.
	assign deadline_prod = {10'd0, cfg_data} * {23'd0, US_PER_MS};
	assign deadline_new  = deadline_prod[32] ? 32'hFFFF_FFFF : deadline_prod[31:0];

	assign floor_sel = (noise_floor_q < floor_min_q || noise_floor_q > floor_max_q)
		? floor_default_q : noise_floor_q;
	assign thr_sel   = (floor_sel > signal_margin_q) ? floor_sel - signal_margin_q : 7'd0;

	// State as it stands after the sample update, before any burst is closed.
	assign v8     = {1'b0, rssi};
	assign active = is_sample && (rssi <= threshold_q);
	assign ib_mid = active ? 1'b1 : burst_on_q;
	assign bb_mid = (active && !burst_on_q) ? time_us : burst_begin_q;
	always_comb begin
		bs_mid = burst_strongest_q;
		if (active) begin
			if (!burst_on_q || v8 < burst_strongest_q)
				bs_mid = v8;
		end
	end
	assign ov_mid = (is_sample && v8 < overall_strongest_q) ? v8 : overall_strongest_q;

	assign t_now   = is_sample ? time_us : latest_time_q;
	assign elapsed = t_now - window_start_q;
	assign end_w   = is_sample ? (elapsed >= deadline_q) : 1'b1;

	// A burst closes on an inactive sample or when the window ends.
	assign close = ib_mid && (end_w || !active);
	assign blen  = t_now - bb_mid;
	assign rec   = close && (recorded_q < rec_limit_q);

	assign on_next         = on_sum_q + (close ? blen : 32'd0);
	assign recorded_next   = recorded_q + {15'd0, rec};
	assign overflowed_next = (close && !rec && overflowed_q != LEN_SAT)
		? overflowed_q + 16'd1 : overflowed_q;

	assign push = win_step && (rec || end_w);

	always_comb begin
		push_entry.has_rec   = rec;
		push_entry.has_sum   = end_w;
		push_entry.rec_start = bb_mid - window_start_q;
		push_entry.rec_len   = (blen[31:16] != 16'd0) ? LEN_SAT : blen[15:0];
		push_entry.rec_peak  = bs_mid;
		push_entry.win_len   = elapsed;
		push_entry.on_time   = on_next;
		push_entry.count     = recorded_next;
		push_entry.dropped   = overflowed_next;
		push_entry.floor_val = floor_latched_q;
		push_entry.win_peak  = ov_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_floor_q   <= 7'd90;
			floor_default_q <= 7'd90;
			floor_min_q     <= 7'd0;
			floor_max_q     <= 7'd127;
			signal_margin_q <= 7'd10;
			win_ms_q        <= 23'd1000;
			rec_limit_q     <= 16'd64;
			deadline_q      <= 32'd1_000_000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOISE_FLOOR:   noise_floor_q   <= cfg_data[6:0];
				REG_FLOOR_DEFAULT: floor_default_q <= cfg_data[6:0];
				REG_FLOOR_MIN:     floor_min_q     <= cfg_data[6:0];
				REG_FLOOR_MAX:     floor_max_q     <= cfg_data[6:0];
				REG_SIGNAL_MARGIN: signal_margin_q <= cfg_data[6:0];
				REG_WINDOW_MS: begin
					win_ms_q   <= cfg_data;
					deadline_q <= deadline_new;
				end
				REG_MAX_BURSTS:    rec_limit_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q       <= 1'b0;
			window_start_q      <= 32'd0;
			latest_time_q       <= 32'd0;
			threshold_q         <= 7'd0;
			floor_latched_q     <= 7'd0;
			burst_on_q          <= 1'b0;
			burst_begin_q       <= 32'd0;
			burst_strongest_q   <= INVALID_RSSI;
			overall_strongest_q <= INVALID_RSSI;
			recorded_q          <= 16'd0;
			overflowed_q        <= 16'd0;
			on_sum_q            <= 32'd0;
		end else if (accept && mode == MODE_START) begin
			window_open_q <= start_ok;
			if (start_ok) begin
				floor_latched_q     <= floor_sel;
				threshold_q         <= thr_sel;
				window_start_q      <= time_us;
				latest_time_q       <= time_us;
				burst_on_q          <= 1'b0;
				burst_begin_q       <= 32'd0;
				burst_strongest_q   <= INVALID_RSSI;
				overall_strongest_q <= INVALID_RSSI;
				recorded_q          <= 16'd0;
				overflowed_q        <= 16'd0;
				on_sum_q            <= 32'd0;
			end
		end else if (win_step) begin
			window_open_q       <= !end_w;
			latest_time_q       <= t_now;
			burst_on_q          <= ib_mid && !close;
			burst_begin_q       <= bb_mid;
			burst_strongest_q   <= bs_mid;
			overall_strongest_q <= ov_mid;
			recorded_q          <= recorded_next;
			overflowed_q        <= overflowed_next;
			on_sum_q            <= on_next;
		end
	end

endmodule

`default_nettype wire

[src/rbd_fifo.sv]
// Short queue of result entries between the front and back parts.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rbd_pkg::rbd_entry_t push_data,
	output logic                     full,
	input  wire logic                pop,
	output rbd_pkg::rbd_entry_t      pop_data,
	output logic                     empty
);
	import rbd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rbd_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

[src/rbd_back.sv]
// Back part of the burst detector: expands each queue entry into its burst
// record, its window summary or both, and holds them in the output register.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rbd_pkg::rbd_entry_t head,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic                    kind,
	output logic [31:0]             rec_offset_us,
	output logic [15:0]             burst_len_us,
	output logic [7:0]              rec_peak_rssi,
	output logic [31:0]             window_len_us,
	output logic [31:0]             on_time_us,
	output logic [15:0]             burst_count,
	output logic [15:0]             dropped_count,
	output logic [6:0]              floor_used,
	output logic [7:0]              window_peak,
	output logic                    last
);
	import rbd_pkg::*;

	logic        valid_q, rec_done_q;
	logic        kind_q, last_q;
	logic [31:0] start_q, wlen_q, on_q;
	logic [15:0] len_q, count_q, dropped_q;
	logic [7:0]  peak_q, wpeak_q;
	logic [6:0]  floor_q;
	logic        load, show_rec;

	// The output register takes a new request when it is empty or being taken.
	assign load     = !empty && (!valid_q || !res_stall);
	assign show_rec = head.has_rec && !rec_done_q;
	assign pop      = load && !(show_rec && head.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			rec_done_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!res_stall)
				valid_q <= 1'b0;
			if (load)
				rec_done_q <= show_rec && head.has_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (show_rec) begin
				kind_q    <= KIND_RECORD;
				start_q   <= head.rec_start;
				len_q     <= head.rec_len;
				peak_q    <= head.rec_peak;
				wlen_q    <= 32'd0;
				on_q      <= 32'd0;
				count_q   <= 16'd0;
				dropped_q <= 16'd0;
				floor_q   <= 7'd0;
				wpeak_q   <= 8'd0;
				last_q    <= !head.has_sum;
			end else begin
				kind_q    <= KIND_SUMMARY;
				start_q   <= 32'd0;
				len_q     <= 16'd0;
				peak_q    <= 8'd0;
				wlen_q    <= head.win_len;
				on_q      <= head.on_time;
				count_q   <= head.count;
				dropped_q <= head.dropped;
				floor_q   <= head.floor_val;
				wpeak_q   <= head.win_peak;
				last_q    <= 1'b1;
			end
		end
	end

	assign res_valid      = valid_q;
	assign kind           = kind_q;
	assign rec_offset_us  = start_q;
	assign burst_len_us   = len_q;
	assign rec_peak_rssi  = peak_q;
	assign window_len_us  = wlen_q;
	assign on_time_us     = on_q;
	assign burst_count    = count_q;
	assign dropped_count  = dropped_q;
	assign floor_used     = floor_q;
	assign window_peak    = wpeak_q;
	assign last           = last_q;

endmodule

`default_nettype wire

[src/rssi_burst_detector.sv]
// RSSI burst detector: a start item opens an observation window, samples at or
// below the threshold form bursts, and each closed burst yields a record up to
// the burst limit while the window yields a summary at its end. The front part
// takes one input item per cycle while the QUEUE_DEPTH-entry result queue has
// room; an item's first result enters the queue on acceptance and then moves to
// the output register, which hands out one result per cycle while res_stall is
// low, so an item with both a record and a summary holds it for both in turn;
// the queue depth sets how many such items can be absorbed while res_stall is
// high. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Depends on rbd_pkg, rbd_front, rbd_fifo and rbd_back.
`timescale 1ns / 1ps
`default_nettype none

module rssi_burst_detector #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [22:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [6:0]  rssi,
	input  wire logic [31:0] time_us,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             kind,
	output logic [31:0]      rec_offset_us,
	output logic [15:0]      burst_len_us,
	output logic [7:0]       rec_peak_rssi,
	output logic [31:0]      window_len_us,
	output logic [31:0]      on_time_us,
	output logic [15:0]      burst_count,
	output logic [15:0]      dropped_count,
	output logic [6:0]       floor_used,
	output logic [7:0]       window_peak,
	output logic             last
);
	import rbd_pkg::*;

	rbd_entry_t push_entry, head;
	logic       push, full, pop, empty;

	rbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.rssi       (rssi),
		.time_us    (time_us),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	rbd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	rbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.kind           (kind),
		.rec_offset_us  (rec_offset_us),
		.burst_len_us   (burst_len_us),
		.rec_peak_rssi  (rec_peak_rssi),
		.window_len_us  (window_len_us),
		.on_time_us     (on_time_us),
		.burst_count    (burst_count),
		.dropped_count  (dropped_count),
		.floor_used     (floor_used),
		.window_peak    (window_peak),
		.last           (last)
	);

endmodule

`default_nettype wire
